FILE: hw/rtl/blms_pkg.sv
package blms_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TEST,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_PQ,
		ST_CHK1,
		ST_CHK2,
		ST_DIV,
		ST_ADJ,
		ST_GOLD,
		ST_FIN,
		ST_OUT
	} blms_state_t;

	typedef enum logic [1:0] {
		CAUSE_RUN = 2'd0,
		CAUSE_TOL = 2'd1,
		CAUSE_LIM = 2'd2
	} blms_cause_t;

	localparam logic CFG_REL_TOL   = 1'b0;
	localparam logic CFG_MAX_EVALS = 1'b1;

	localparam logic OP_START = 1'b0;
	localparam logic OP_VALUE = 1'b1;

	localparam logic [15:0] EVAL_SAT = 16'hFFFF;
	localparam logic [31:0] CGOLD_Q32 = 32'd1640531527;

	typedef struct packed {
		logic load_start;
		logic load_value;
		logic do_test;
		logic do_m1;
		logic do_m2;
		logic do_m3;
		logic do_pq;
		logic do_chk1;
		logic do_chk2;
		logic div_start;
		logic do_adj;
		logic do_gold;
		logic do_fin;
	} blms_cmd_t;

	typedef struct packed {
		logic stop;
		logic try_parab;
		logic accept_parab;
		logic div_done;
	} blms_status_t;

endpackage

FILE: hw/rtl/blms_divider.sv
module blms_divider #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

FILE: hw/rtl/blms_datapath.sv
module blms_datapath #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  blms_pkg::blms_cmd_t           cmd,
	output blms_pkg::blms_status_t        status,
	input  logic [15:0]                   rel_tol,
	input  logic [15:0]                   max_evals,
	input  logic signed [VALUE_WIDTH-1:0] in_lo,
	input  logic signed [VALUE_WIDTH-1:0] in_hi,
	input  logic signed [VALUE_WIDTH-1:0] in_x,
	input  logic signed [VALUE_WIDTH-1:0] in_f,
	output logic signed [VALUE_WIDTH-1:0] probe,
	output logic signed [VALUE_WIDTH-1:0] bx,
	output logic signed [VALUE_WIDTH-1:0] bf,
	output logic [1:0]                    cause
);
	import blms_pkg::*;

	localparam int V  = VALUE_WIDTH;
	localparam int E  = V + 4;
	localparam int PW = 2 * V + 4;
	localparam int DW = V + FRACTION_BITS + 2;

	localparam logic signed [E-1:0] VMAX = E'((65'sd1 <<< (V - 1)) - 1);
	localparam logic signed [E-1:0] VMIN = -VMAX - E'(1);

	function automatic logic signed [E-1:0] sat_e(input logic signed [E-1:0] v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	function automatic logic signed [V-1:0] sat_v(input logic signed [E-1:0] v);
		logic signed [E-1:0] s;
		s = sat_e(v);
		return s[V-1:0];
	endfunction

	function automatic logic signed [E-1:0] ex(input logic signed [V-1:0] v);
		return E'(v);
	endfunction

	function automatic logic signed [E-1:0] absv(input logic signed [E-1:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [V-1:0] rnd(input logic signed [PW-1:0] p,
		input int n);
		logic signed [PW-1:0] t;
		logic signed [PW-1:0] vm;
		t  = (p + (PW'(1) <<< (n - 1))) >>> n;
		vm = PW'(VMAX);
		if (t > vm) return VMAX[V-1:0];
		if (t < -vm - PW'(1)) return VMIN[V-1:0];
		return t[V-1:0];
	endfunction

	logic signed [V-1:0] a_q, b_q, x_q, w_q, v_q, fx_q, fw_q, fv_q, d_q, e_q, u_q;
	logic [15:0]         cnt_q;
	logic signed [V-1:0] xm_q, tol1_q, r_q, q_q, p_q, t1_q, etemp_q;
	logic [V:0]          qdiv_q;
	logic                stop_q, tryp_q, acc_q;
	logic [1:0]          cause_q;

	logic signed [E-1:0] ma, mb;
	logic [5:0]          mshift;
	logic signed [PW-1:0] prod;
	logic signed [V-1:0] mres;

	logic signed [E-1:0] lo_e, hi_e;
	logic signed [E-1:0] xm_c, tol1_c, tol2_c;
	logic [DW-1:0]       div_q;
	logic                div_done;
	logic                p_neg_q;
	logic [DW-1:0]       dvd, dvs;

	assign prod = PW'(ma) * PW'(mb);
	assign mres = rnd(prod, int'(mshift));

	always_comb begin
		ma = '0;
		mb = '0;
		mshift = 6'(FRACTION_BITS);
		if (cmd.do_test) begin
			ma = E'($signed({1'b0, rel_tol}));
			mb = absv(ex(x_q));
			mshift = 6'd16;
		end else if (cmd.do_m1) begin
			ma = sat_e(ex(x_q) - ex(w_q));
			mb = sat_e(ex(fx_q) - ex(fv_q));
		end else if (cmd.do_m2) begin
			ma = sat_e(ex(x_q) - ex(v_q));
			mb = sat_e(ex(fx_q) - ex(fw_q));
		end else if (cmd.do_m3) begin
			ma = sat_e(ex(x_q) - ex(v_q));
			mb = ex(q_q);
		end else if (cmd.do_pq) begin
			ma = sat_e(ex(x_q) - ex(w_q));
			mb = ex(r_q);
		end else if (cmd.do_chk1) begin
			ma = ex(q_q);
			mb = ex(etemp_q);
			mshift = 6'(FRACTION_BITS + 1);
		end else if (cmd.do_chk2) begin
			ma = ex(q_q);
			mb = sat_e(ex(a_q) - ex(x_q));
		end else if (cmd.do_adj) begin
			ma = ex(q_q);
			mb = sat_e(ex(b_q) - ex(x_q));
		end
	end

	always_comb begin
		lo_e   = ex(a_q);
		hi_e   = ex(b_q);
		xm_c   = (lo_e + hi_e) >>> 1;
		tol1_c = sat_e(ex(mres) + E'(1));
		tol2_c = tol1_c <<< 1;
	end

	assign dvd = DW'(absv(ex(p_q))) << FRACTION_BITS;
	assign dvs = DW'(qdiv_q);

	blms_divider #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	logic signed [E-1:0]  tol1e, tol2e, xe, de;
	logic signed [DW+1:0] dq_s;
	logic signed [E-1:0]  d_div, u_try, d_adj, e_g, d_g;
	logic signed [PW-1:0] gprod;
	logic signed [V-1:0]  q_abs_c;
	logic signed [E-1:0]  q2, qa_c, pd_c;
	logic signed [E-1:0]  dfin;
	logic signed [E-1:0]  ufin2;

	always_comb begin
		tol1e  = ex(tol1_q);
		tol2e  = tol1e <<< 1;
		xe     = ex(x_q);
		de     = ex(d_q);
		dq_s   = p_neg_q ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
		if (dq_s > (DW+2)'(VMAX)) d_div = VMAX;
		else if (dq_s < (DW+2)'(VMIN)) d_div = VMIN;
		else d_div = E'(dq_s);
		u_try  = xe + d_div;
		d_adj  = ((u_try - ex(a_q) < tol2e) || (ex(b_q) - u_try < tol2e)) ?
			((ex(xm_q) - xe >= 0) ? tol1e : -tol1e) : d_div;
		e_g    = sat_e(xe >= ex(xm_q) ? ex(a_q) - xe : ex(b_q) - xe);
		gprod  = PW'(e_g) * PW'($signed({1'b0, CGOLD_Q32}));
		d_g    = ex(rnd(gprod, 32));
		q2      = sat_e((ex(q_q) - ex(r_q)) <<< 1);
		qa_c    = absv(q2);
		q_abs_c = sat_v(qa_c);
		pd_c    = sat_e(ex(t1_q) - ex(mres));
	end

	assign dfin  = ex(d_q);
	assign ufin2 = sat_e(absv(dfin) >= tol1e ? xe + dfin : xe + ((dfin >= 0) ? tol1e : -tol1e));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; b_q <= '0; x_q <= '0; w_q <= '0; v_q <= '0;
			fx_q <= '0; fw_q <= '0; fv_q <= '0; d_q <= '0; e_q <= '0; u_q <= '0;
			cnt_q <= '0; cause_q <= CAUSE_RUN; stop_q <= 1'b0;
			tryp_q <= 1'b0; acc_q <= 1'b0;
		end else begin
			if (cmd.load_start) begin
				a_q <= (in_lo < in_hi) ? in_lo : in_hi;
				b_q <= (in_lo < in_hi) ? in_hi : in_lo;
				x_q <= in_x; w_q <= in_x; v_q <= in_x;
				fx_q <= in_f; fw_q <= in_f; fv_q <= in_f;
				d_q <= '0; e_q <= '0; u_q <= '0;
				cnt_q <= 16'd1;
			end
			if (cmd.load_value) begin
				if (in_f <= fx_q) begin
					if (u_q >= x_q) a_q <= x_q; else b_q <= x_q;
					v_q <= w_q; w_q <= x_q; x_q <= u_q;
					fv_q <= fw_q; fw_q <= fx_q; fx_q <= in_f;
				end else begin
					if (u_q < x_q) a_q <= u_q; else b_q <= u_q;
					if (in_f <= fw_q || w_q == x_q) begin
						v_q <= w_q; w_q <= u_q; fv_q <= fw_q; fw_q <= in_f;
					end else if (in_f <= fv_q || v_q == x_q || v_q == w_q) begin
						v_q <= u_q; fv_q <= in_f;
					end
				end
				if (cnt_q != EVAL_SAT) cnt_q <= cnt_q + 16'd1;
			end
			if (cmd.do_test) begin
				xm_q   <= xm_c[V-1:0];
				tol1_q <= tol1_c[V-1:0];
				if (absv(ex(x_q) - xm_c) <= tol2_c - (hi_e - lo_e) / E'(2)) begin
					cause_q <= CAUSE_TOL; stop_q <= 1'b1;
				end else if (cnt_q >= max_evals) begin
					cause_q <= CAUSE_LIM; stop_q <= 1'b1;
				end else begin
					cause_q <= CAUSE_RUN; stop_q <= 1'b0;
				end
				tryp_q  <= absv(ex(e_q)) > tol1_c;
				etemp_q <= e_q;
				acc_q   <= 1'b0;
			end
			if (cmd.do_m1) r_q <= mres;
			if (cmd.do_m2) q_q <= mres;
			if (cmd.do_m3) t1_q <= mres;
			if (cmd.do_pq) begin
				p_q    <= (q2 > 0) ? sat_v(-pd_c) : pd_c[V-1:0];
				q_q    <= q_abs_c;
				qdiv_q <= qa_c[V:0];
				e_q    <= d_q;
			end
			if (cmd.do_chk1) begin
				acc_q <= !(absv(ex(p_q)) >= absv(ex(mres))) && (q_q > 0);
			end
			if (cmd.do_chk2) begin
				if (p_q <= mres) acc_q <= 1'b0;
				p_neg_q <= p_q < 0;
			end
			if (cmd.do_adj) begin
				if (p_q >= mres) acc_q <= 1'b0;
			end
			if (cmd.do_gold) begin
				e_q <= e_g[V-1:0];
				d_q <= d_g[V-1:0];
			end
			if (cmd.do_fin) begin
				if (acc_q) begin
					d_q <= sat_v(d_adj);
					u_q <= sat_v(absv(d_adj) >= tol1e ? xe + d_adj :
						xe + ((d_adj >= 0) ? tol1e : -tol1e));
				end else begin
					u_q <= ufin2[V-1:0];
				end
			end
		end
	end

	assign status = {stop_q, tryp_q, acc_q, div_done};
	assign probe = stop_q ? '0 : u_q;
	assign bx    = x_q;
	assign bf    = fx_q;
	assign cause = cause_q;
endmodule

FILE: hw/rtl/blms_ctrl.sv
module blms_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_op,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output blms_pkg::blms_cmd_t    cmd,
	input  blms_pkg::blms_status_t status
);
	import blms_pkg::*;

	blms_state_t state_q, state_d;
	logic        run_q, run_d;
	logic        acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			run_q   <= run_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		run_d     = run_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		acc       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				acc = in_valid;
				if (acc && in_op == OP_START) begin
					cmd.load_start = 1'b1;
					run_d = 1'b1;
					state_d = ST_TEST;
				end else if (acc && run_q) begin
					cmd.load_value = 1'b1;
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				cmd.do_test = 1'b1;
				state_d = ST_M1;
			end
			ST_M1: begin
				if (status.stop) begin
					run_d = 1'b0;
					state_d = ST_OUT;
				end else if (status.try_parab) begin
					cmd.do_m1 = 1'b1;
					state_d = ST_M2;
				end else begin
					state_d = ST_GOLD;
				end
			end
			ST_M2: begin
				cmd.do_m2 = 1'b1;
				state_d = ST_M3;
			end
			ST_M3: begin
				cmd.do_m3 = 1'b1;
				state_d = ST_PQ;
			end
			ST_PQ: begin
				cmd.do_pq = 1'b1;
				state_d = ST_CHK1;
			end
			ST_CHK1: begin
				cmd.do_chk1 = 1'b1;
				state_d = ST_CHK2;
			end
			ST_CHK2: begin
				cmd.do_chk2 = 1'b1;
				state_d = ST_ADJ;
			end
			ST_ADJ: begin
				cmd.do_adj = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!status.accept_parab) begin
					state_d = ST_GOLD;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_GOLD: begin
				cmd.do_gold = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!status.accept_parab || status.div_done) begin
					cmd.do_fin = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

FILE: hw/rtl/brent_line_minimizer_step_unit.sv
// Brent line minimizer step unit. Send a start request (opcode 0) with the bracket,
// an interior point and f there; each returned probe_point must be evaluated and
// sent back as a value request (opcode 1). Every accepted request yields one result
// until done_res is set; value requests while stopped are dropped. A new request is
// taken only after the last result is taken. The search stops after the test step;
// otherwise a golden step follows when no parabolic trial is tried, and a trial runs
// multiply and check steps, takes a golden step if rejected, else waits on the divider
// (bit-serial, one quotient bit per cycle over VALUE_WIDTH+FRACTION_BITS+2 bits).
module brent_line_minimizer_step_unit #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// opcode, bracket_low, bracket_high, start_point, func_value (padded)
	input  logic [4*VALUE_WIDTH+7:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// probe_point, best_point, best_value, done_res, stop_cause (padded)
	output logic [3*VALUE_WIDTH+7:0]     m_tdata,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [15:0]                  cfg_data
);
	import blms_pkg::*;

	localparam int V = VALUE_WIDTH;

	logic [15:0]   rel_tol_q, max_evals_q;
	blms_cmd_t     cmd;
	blms_status_t  status;
	logic signed [V-1:0] probe, bx, bf;
	logic [1:0]    cause;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_tol_q   <= 16'd655;
			max_evals_q <= 16'd10000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REL_TOL:   rel_tol_q   <= cfg_data;
				CFG_MAX_EVALS: max_evals_q <= cfg_data;
				default: ;
			endcase
		end
	end

	blms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (s_tdata[0]),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.status    (status)
	);

	blms_datapath #(.VALUE_WIDTH(V), .FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.rel_tol   (rel_tol_q),
		.max_evals (max_evals_q),
		.in_lo     (s_tdata[V:1]),
		.in_hi     (s_tdata[2*V:V+1]),
		.in_x      (s_tdata[3*V:2*V+1]),
		.in_f      (s_tdata[4*V:3*V+1]),
		.probe     (probe),
		.bx        (bx),
		.bf        (bf),
		.cause     (cause)
	);

	assign m_tdata = {5'd0, cause, (cause != CAUSE_RUN), bf, bx, probe};
endmodule
